>>> rtl/bvm_pkg.sv
// Shared constants, register indexes and a lookup function for the battery
// voltage monitor. No dependencies; every rtl file imports this package.
package bvm_pkg;

  localparam int MaxSamplesDef = 64;
  localparam int SampleW       = 12;
  localparam int PinW          = 12;
  localparam int BattW         = 15;
  localparam int PctW          = 7;
  localparam int DivNumW       = 25;
  localparam int DivDenW       = 16;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 16;

  localparam logic [CfgIdxW-1:0] RegAtten   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRatio   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegEmpty   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFull    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSamples = 3'd4;

  localparam logic [BattW-1:0] BattMin = 15'd100;
  localparam logic [BattW-1:0] BattMax = 15'd20000;

  // ADC full scale in mV for each attenuation code
  function automatic logic [11:0] fullscale_mv(input logic [1:0] code);
    logic [11:0] fs;
    case (code)
      2'd0:    fs = 12'd950;
      2'd1:    fs = 12'd1250;
      2'd2:    fs = 12'd1750;
      default: fs = 12'd3100;
    endcase
    return fs;
  endfunction

endpackage

>>> rtl/bvm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bvm_pkg for operand widths.
module bvm_div
  import bvm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o
);

  localparam int StepW = $clog2(DivNumW);

  logic               busy_q;
  logic               done_q;
  logic [StepW-1:0]   step_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivNumW-1:0] quo_q;
  logic [DivDenW:0]   trial;
  logic               fits;

  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? DivDenW'(trial - {1'b0, den_q}) : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/bvm_trim.sv
// Sample store and trimmed-sum sequencer: ranks each stored sample by a
// sweep over the store and sums those outside the trimmed tails. Uses bvm_pkg.
module bvm_trim
  import bvm_pkg::*;
#(
  parameter int MaxSamples = MaxSamplesDef,
  parameter int Cw         = $clog2(MaxSamples + 1),
  parameter int Aw         = (MaxSamples > 1) ? $clog2(MaxSamples) : 1,
  parameter int SumW       = SampleW + Cw
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [Aw-1:0]      wr_addr_i,
  input  logic [SampleW-1:0] wr_data_i,
  input  logic               start_i,
  input  logic [Cw-1:0]      n_i,
  output logic               done_o,
  output logic [SumW-1:0]    sum_o
);

  typedef enum logic [2:0] {
    T_IDLE, T_RD_I, T_LAT_I, T_RD_J, T_CMP, T_ACC
  } trim_state_e;

  trim_state_e        state_q;
  logic [SampleW-1:0] mem [MaxSamples];
  logic [SampleW-1:0] rdata_q;
  logic [SampleW-1:0] vi_q;
  logic [Aw-1:0]      i_q, j_q, rd_addr;
  logic [Cw-1:0]      n_q, rank_q, trim, hi, n_m1;
  logic [SumW-1:0]    sum_q;
  logic               done_q;
  logic               below;

  assign rd_addr = (state_q == T_RD_I) ? i_q : j_q;
  assign trim    = n_q >> 3;
  assign hi      = n_q - trim;
  assign n_m1    = n_q - 1'b1;
  assign below   = (rdata_q < vi_q) || ((rdata_q == vi_q) && (j_q < i_q));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      rank_q  <= '0;
      vi_q    <= '0;
      sum_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        T_IDLE: begin
          if (start_i) begin
            n_q     <= n_i;
            i_q     <= '0;
            sum_q   <= '0;
            state_q <= T_RD_I;
          end
        end
        T_RD_I: state_q <= T_LAT_I;
        T_LAT_I: begin
          vi_q    <= rdata_q;
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= T_RD_J;
        end
        T_RD_J: state_q <= T_CMP;
        T_CMP: begin
          if (below) begin
            rank_q <= rank_q + 1'b1;
          end
          if (j_q == n_m1[Aw-1:0]) begin
            state_q <= T_ACC;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= T_RD_J;
          end
        end
        T_ACC: begin
          // keep only samples whose sorted position lies between the trimmed tails
          if (rank_q >= trim && rank_q < hi) begin
            sum_q <= sum_q + SumW'(vi_q);
          end
          if (i_q == n_m1[Aw-1:0]) begin
            done_q  <= 1'b1;
            state_q <= T_IDLE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= T_RD_I;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

>>> rtl/battery_voltage_monitor_unit.sv
// Battery voltage monitor: burst intake, trimmed mean, filter, scaling, status.
// Throughput: one sample word per cycle while in intake. At a burst end, the n valid
// samples are ranked, averaged in the shared divider, then pass pin conversion,
// scaling, status (the percent may take a second divider pass) and output before the
// result word is valid. Input is not taken meanwhile. Reset clears counters, filter,
// previous status and registers to defaults. Depends on bvm_pkg, bvm_trim and bvm_div.
module battery_voltage_monitor_unit
  import bvm_pkg::*;
#(
  parameter int MaxSamples = MaxSamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  raw_sample_i,
  input  logic                sample_ok_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BattW-1:0]    battery_mv_o,
  output logic [PinW-1:0]     pin_mv_o,
  output logic [PctW-1:0]     charge_percent_o,
  output logic                is_low_o,
  output logic                is_depleted_o,
  output logic                status_moved_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Cw   = $clog2(MaxSamples + 1);
  localparam int Aw   = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int SumW = SampleW + Cw;

  // ceil(2^36 / 4095); exact quotient over the whole pin numerator range
  localparam logic [24:0] PinRecip = 25'd16781314;

  typedef enum logic [3:0] {
    S_IN, S_TRIM, S_DIV_AVG, S_PIN, S_SCALE, S_PCT, S_DIV_PCT, S_EMIT
  } mon_state_e;

  mon_state_e state_q;

  logic [1:0]          atten_q;
  logic [15:0]         ratio_q;
  logic [BattW-1:0]    empty_q, full_q;
  logic [6:0]          samples_q;
  logic [Cw-1:0]       att_q, vcnt_q, n_q, target, att_nx, vcnt_nx, cnt;
  logic [PinW-1:0]     filt_q;
  logic [1:0]          primed_q;
  logic [BattW-1:0]    batt_q, prev_batt_q;
  logic [PinW-1:0]     prev_pin_q;
  logic [8:0]          prev_flags_q;
  logic [PctW-1:0]     pct_q;
  logic                low_q, crit_q;
  logic                ov_q;
  logic [BattW-1:0]    ob_q;
  logic [PinW-1:0]     op_q;
  logic [PctW-1:0]     opct_q;
  logic                olow_q, ocrit_q, ochg_q;

  logic                in_acc, keep, trim_go_q, trim_done;
  logic [SumW-1:0]     trim_sum;
  logic                div_go_q, div_done;
  logic [DivNumW-1:0]  div_num_q, div_quot;
  logic [DivDenW-1:0]  div_den_q;

  logic [47:0]         pin_prod;
  logic [PinW-1:0]     pin_est;
  logic [PinW:0]       filt_sum;
  logic [28:0]         scaled;
  logic [20:0]         batt_raw;
  logic [BattW-1:0]    batt_clamp, range, dlt;
  logic [19:0]         low_l, low_r;
  logic [8:0]          flags;
  logic [BattW-1:0]    bdiff;
  logic [PinW-1:0]     pdiff;
  logic                emit;

  assign in_ready_o  = (state_q == S_IN);
  assign cfg_ready_o = (state_q == S_IN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign keep        = sample_ok_i && (vcnt_q < Cw'(MaxSamples));

  always_comb begin
    if (samples_q == 7'd0) begin
      target = Cw'(1);
    end else if (32'(samples_q) > MaxSamples) begin
      target = Cw'(MaxSamples);
    end else begin
      target = Cw'(samples_q);
    end
  end

  assign att_nx  = att_q + 1'b1;
  assign vcnt_nx = keep ? vcnt_q + 1'b1 : vcnt_q;
  assign cnt     = n_q - ((n_q >> 3) << 1);

  bvm_trim #(
    .MaxSamples (MaxSamples),
    .Cw         (Cw),
    .Aw         (Aw),
    .SumW       (SumW)
  ) u_trim (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && keep),
    .wr_addr_i (vcnt_q[Aw-1:0]),
    .wr_data_i (raw_sample_i),
    .start_i   (trim_go_q),
    .n_i       (n_q),
    .done_o    (trim_done),
    .sum_o     (trim_sum)
  );

  bvm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // pin estimate: halve the numerator, then divide by 4095 through the reciprocal
  assign pin_prod   = 48'(div_num_q[DivNumW-1:1]) * 48'(PinRecip);
  assign pin_est    = pin_prod[47:36];

  // finishing arithmetic
  assign filt_sum   = {1'b0, filt_q} + {1'b0, pin_est} + 1'b1;
  assign scaled     = 29'(filt_q) * 29'(ratio_q) + 29'd128;
  assign batt_raw   = (ratio_q == 16'd0) ? 21'(filt_q) : scaled[28:8];
  assign batt_clamp = (batt_raw < 21'(BattMin)) ? BattMin :
                      (batt_raw > 21'(BattMax)) ? BattMax : batt_raw[BattW-1:0];
  assign range      = full_q - empty_q;
  assign dlt        = batt_q - empty_q;
  assign low_l      = 20'(batt_q) * 20'd10;
  assign low_r      = 20'(empty_q) * 20'd9 + 20'(full_q);
  assign flags      = {crit_q, low_q, pct_q};
  assign bdiff      = (batt_q > prev_batt_q) ? batt_q - prev_batt_q : prev_batt_q - batt_q;
  assign pdiff      = (filt_q > prev_pin_q) ? filt_q - prev_pin_q : prev_pin_q - filt_q;
  assign emit       = (state_q == S_EMIT) && (!ov_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IN;
      atten_q      <= 2'd3;
      ratio_q      <= 16'd256;
      empty_q      <= '0;
      full_q       <= '0;
      samples_q    <= 7'd64;
      att_q        <= '0;
      vcnt_q       <= '0;
      n_q          <= '0;
      filt_q       <= '0;
      primed_q     <= '0;
      batt_q       <= '0;
      prev_batt_q  <= '0;
      prev_pin_q   <= '0;
      prev_flags_q <= '0;
      pct_q        <= '0;
      low_q        <= 1'b0;
      crit_q       <= 1'b0;
      ov_q         <= 1'b0;
      trim_go_q    <= 1'b0;
      div_go_q     <= 1'b0;
      div_num_q    <= '0;
      div_den_q    <= '0;
    end else begin
      trim_go_q <= 1'b0;
      div_go_q  <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegAtten: begin
            atten_q  <= cfg_data_i[1:0];
            primed_q <= '0;
          end
          RegRatio: begin
            ratio_q  <= cfg_data_i;
            primed_q <= '0;
          end
          RegEmpty:   empty_q   <= cfg_data_i[BattW-1:0];
          RegFull:    full_q    <= cfg_data_i[BattW-1:0];
          RegSamples: samples_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (ov_q && out_ready_i && !emit) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IN: begin
          if (in_acc) begin
            if (att_nx >= target) begin
              att_q  <= '0;
              vcnt_q <= '0;
              n_q    <= vcnt_nx;
              if (vcnt_nx != '0) begin
                trim_go_q <= 1'b1;
                state_q   <= S_TRIM;
              end
            end else begin
              att_q  <= att_nx;
              vcnt_q <= vcnt_nx;
            end
          end
        end
        S_TRIM: begin
          if (trim_done) begin
            div_num_q <= DivNumW'(trim_sum);
            div_den_q <= DivDenW'(cnt);
            div_go_q  <= 1'b1;
            state_q   <= S_DIV_AVG;
          end
        end
        S_DIV_AVG: begin
          if (div_done) begin
            div_num_q <= DivNumW'({24'(div_quot[SampleW-1:0]) * 24'(fullscale_mv(atten_q)),
                                   1'b0}) + DivNumW'(4095);
            state_q   <= S_PIN;
          end
        end
        S_PIN: begin
          // start-up: pass the first three values, then blend half and half
          if (primed_q != 2'd3) begin
            filt_q   <= pin_est;
            primed_q <= primed_q + 1'b1;
          end else begin
            filt_q <= filt_sum[PinW:1];
          end
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          batt_q  <= batt_clamp;
          state_q <= S_PCT;
        end
        S_PCT: begin
          crit_q <= (batt_q <= empty_q);
          low_q  <= (low_l <= low_r);
          if (batt_q <= empty_q) begin
            pct_q   <= '0;
            state_q <= S_EMIT;
          end else if (batt_q >= full_q) begin
            pct_q   <= PctW'(100);
            state_q <= S_EMIT;
          end else if (range > BattW'(10)) begin
            div_num_q <= DivNumW'(23'(dlt) * 23'd200) + DivNumW'(range);
            div_den_q <= {range, 1'b0};
            div_go_q  <= 1'b1;
            state_q   <= S_DIV_PCT;
          end else begin
            pct_q   <= '0;
            state_q <= S_EMIT;
          end
        end
        S_DIV_PCT: begin
          if (div_done) begin
            pct_q   <= (div_quot > DivNumW'(100)) ? PctW'(100) : div_quot[PctW-1:0];
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            ov_q         <= 1'b1;
            prev_flags_q <= flags;
            prev_batt_q  <= batt_q;
            prev_pin_q   <= filt_q;
            state_q      <= S_IN;
          end
        end
        default: state_q <= S_IN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q    <= batt_q;
      op_q    <= filt_q;
      opct_q  <= pct_q;
      olow_q  <= low_q;
      ocrit_q <= crit_q;
      ochg_q  <= (flags != prev_flags_q) || (bdiff > BattW'(50)) || (pdiff > PinW'(20));
    end
  end

  assign out_valid_o      = ov_q;
  assign battery_mv_o     = ob_q;
  assign pin_mv_o         = op_q;
  assign charge_percent_o = opct_q;
  assign is_low_o         = olow_q;
  assign is_depleted_o    = ocrit_q;
  assign status_moved_o   = ochg_q;

endmodule
